// File: design/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types and fixed field widths of the heap sort engine.
// ----------------------------------------------------------------------------
package hse_pkg;

	// width of the key fields on both channels
	localparam int FIELD_W = 32;

	// sequencer states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_BUILD_RD,
		ST_BUILD_FETCH,
		ST_SIFT_CMP,
		ST_SIFT_END,
		ST_EXT_RD,
		ST_EXT_SWAP,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

endpackage

// File: design/heap_sort_engine.sv
// ----------------------------------------------------------------------------
// heap_sort_engine
// Collects signed keys into a one-based store, heap sorts them ascending in
// place when the last key of a set arrives, then streams the sorted set out.
// ----------------------------------------------------------------------------
// Loading accepts one key per cycle. Sift-down runs one compare step per cycle
// on the dual-read key memory, in both the build and the extraction phase.
// Each sorted key is read in ST_EMIT_RD, which waits while the output is held,
// and is loaded into the output register in ST_EMIT_WR.
// Reset clears the sequencer, key count, drop flag and output valid; the key
// store is not cleared and is only read where written in the current set.
module heap_sort_engine #(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [hse_pkg::FIELD_W-1:0] key_value,
	input  logic                              last_key,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [hse_pkg::FIELD_W-1:0] sorted_key,
	output logic                              last_out,
	output logic                              overflowed
);
	import hse_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int NW = CW + 1;
	localparam int IW = $clog2(CAPACITY);

	// signed order on stored keys
	function automatic logic key_less(input logic [KEY_WIDTH-1:0] a,
	                                  input logic [KEY_WIDTH-1:0] b);
		key_less = $signed(a) < $signed(b);
	endfunction

	state_t                state_q, state_d;
	logic                  build_q, build_d;
	logic [CW-1:0]         count_q, count_d;
	logic                  drop_q, drop_d;
	logic [CW-1:0]         i_q, i_d;
	logic [CW-1:0]         node_q, node_d;
	logic [CW-1:0]         size_q, size_d;
	logic [CW-1:0]         k_q, k_d;
	logic [KEY_WIDTH-1:0]  v_q, v_d;

	logic                  wr_en;
	logic [NW-1:0]         wr_addr, rd_a_addr, rd_b_addr;
	logic [KEY_WIDTH-1:0]  wr_data;
	logic [KEY_WIDTH-1:0]  rdata_a, rdata_b;
	logic [KEY_WIDTH-1:0]  mem [CAPACITY];
	logic [IW-1:0]         wr_idx, rd_a_idx, rd_b_idx;

	logic                  accept;
	logic                  out_free;
	logic                  out_load;
	logic                  out_valid_q;
	logic [FIELD_W-1:0]    out_key_q;
	logic                  out_last_q, out_drop_q;

	logic [KEY_WIDTH-1:0]  in_key;
	logic [NW-1:0]         left, right, pick, pick_left;
	logic                  pick_right;
	logic [KEY_WIDTH-1:0]  child;
	logic [CW-1:0]         size_less;

	// take the key field at the stored width
	assign in_key = KEY_WIDTH'($unsigned(key_value));

	assign in_stall = (state_q != ST_LOAD);
	assign accept   = in_valid && (state_q == ST_LOAD);
	assign out_free = !out_valid_q || !out_stall;

	// pick the larger child, left on ties
	assign left       = {node_q, 1'b0};
	assign right      = left + NW'(1);
	assign pick_right = (right <= NW'(size_q)) && key_less(rdata_a, rdata_b);
	assign pick       = pick_right ? right : left;
	assign child      = pick_right ? rdata_b : rdata_a;
	assign pick_left  = {pick[CW-1:0], 1'b0};
	assign size_less  = i_q - CW'(1);

	// key memory, one write and two registered reads
	assign wr_idx   = IW'(wr_addr - NW'(1));
	assign rd_a_idx = IW'(rd_a_addr - NW'(1));
	assign rd_b_idx = IW'(rd_b_addr - NW'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		rdata_a <= mem[rd_a_idx];
		rdata_b <= mem[rd_b_idx];
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			build_q <= 1'b1;
			count_q <= '0;
			drop_q  <= 1'b0;
			i_q     <= '0;
			node_q  <= '0;
			size_q  <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			build_q <= build_d;
			count_q <= count_d;
			drop_q  <= drop_d;
			i_q     <= i_d;
			node_q  <= node_d;
			size_q  <= size_d;
			k_q     <= k_d;
		end
	end

	// sifting key, payload only
	always_ff @(posedge clk) begin
		v_q <= v_d;
	end

	// next state, memory control and output load
	always_comb begin
		state_d   = state_q;
		build_d   = build_q;
		count_d   = count_q;
		drop_d    = drop_q;
		i_d       = i_q;
		node_d    = node_q;
		size_d    = size_q;
		k_d       = k_q;
		v_d       = v_q;
		wr_en     = 1'b0;
		wr_addr   = NW'(node_q);
		wr_data   = v_q;
		rd_a_addr = left;
		rd_b_addr = right;
		out_load  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (accept) begin
					if (count_q < CW'(CAPACITY)) begin
						wr_en   = 1'b1;
						wr_addr = NW'(count_q) + NW'(1);
						wr_data = in_key;
						count_d = count_q + CW'(1);
					end else begin
						drop_d = 1'b1;
					end
					if (last_key) begin
						i_d     = count_d >> 1;
						build_d = 1'b1;
						state_d = ST_BUILD_RD;
					end
				end
			end
			ST_BUILD_RD: begin
				if (i_q == '0) begin
					i_d     = count_q;
					build_d = 1'b0;
					state_d = ST_EXT_RD;
				end else begin
					rd_a_addr = NW'(i_q);
					node_d    = i_q;
					size_d    = count_q;
					state_d   = ST_BUILD_FETCH;
				end
			end
			ST_BUILD_FETCH: begin
				v_d = rdata_a;
				if (left <= NW'(size_q)) begin
					state_d = ST_SIFT_CMP;
				end else begin
					i_d     = i_q - CW'(1);
					state_d = ST_BUILD_RD;
				end
			end
			ST_SIFT_CMP: begin
				wr_en = 1'b1;
				if (key_less(v_q, child)) begin
					// move the child up, descend
					wr_data   = child;
					node_d    = pick[CW-1:0];
					rd_a_addr = pick_left;
					rd_b_addr = pick_left + NW'(1);
					if (pick_left <= NW'(size_q)) begin
						state_d = ST_SIFT_CMP;
					end else begin
						state_d = ST_SIFT_END;
					end
				end else if (build_q) begin
					i_d     = i_q - CW'(1);
					state_d = ST_BUILD_RD;
				end else begin
					state_d = ST_EXT_RD;
				end
			end
			ST_SIFT_END: begin
				wr_en = 1'b1;
				if (build_q) begin
					i_d     = i_q - CW'(1);
					state_d = ST_BUILD_RD;
				end else begin
					state_d = ST_EXT_RD;
				end
			end
			ST_EXT_RD: begin
				if (i_q <= CW'(1)) begin
					k_d     = CW'(1);
					state_d = ST_EMIT_RD;
				end else begin
					rd_a_addr = NW'(1);
					rd_b_addr = NW'(i_q);
					state_d   = ST_EXT_SWAP;
				end
			end
			ST_EXT_SWAP: begin
				// root goes to the tail, tail key sifts from the root
				wr_en     = 1'b1;
				wr_addr   = NW'(i_q);
				wr_data   = rdata_a;
				v_d       = rdata_b;
				node_d    = CW'(1);
				size_d    = size_less;
				i_d       = size_less;
				rd_a_addr = NW'(2);
				rd_b_addr = NW'(3);
				if (size_less >= CW'(2)) begin
					state_d = ST_SIFT_CMP;
				end else begin
					state_d = ST_SIFT_END;
				end
			end
			ST_EMIT_RD: begin
				rd_a_addr = NW'(k_q);
				if (out_free) begin
					state_d = ST_EMIT_WR;
				end
			end
			ST_EMIT_WR: begin
				out_load = 1'b1;
				if (k_q == count_q) begin
					count_d = '0;
					drop_d  = 1'b0;
					state_d = ST_LOAD;
				end else begin
					k_d     = k_q + CW'(1);
					state_d = ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_key_q  <= FIELD_W'(rdata_a);
			out_last_q <= (k_q == count_q);
			out_drop_q <= drop_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sorted_key = out_key_q;
	assign last_out   = out_last_q;
	assign overflowed = out_drop_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("key count beyond capacity");

	a_sift_has_child: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SIFT_CMP |-> left <= NW'(size_q))
		else $error("compare step on a node without children");

	a_swap_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXT_SWAP |-> i_q >= CW'(2) && i_q <= count_q)
		else $error("extraction index out of range");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_WR |-> !out_valid_q)
		else $error("result loaded over a pending item");

endmodule
